// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the escape encoder
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/mtee_pkg.sv =====
// ----------------------------------------------------------------------------
// mtee_pkg
// types, constants and the expansion function of the text escape encoder
// ----------------------------------------------------------------------------
package mtee_pkg;

    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int MAX_EXP  = 6;
    localparam int SIZE_W   = 3;
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = 1;
    localparam int QCNT_W   = 2;
    localparam int CFG_IDX_W = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FF_NL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd2;

    // escape modes
    localparam logic [2:0] MODE_HTML = 3'd0;
    localparam logic [2:0] MODE_JS   = 3'd1;
    localparam logic [2:0] MODE_CSS  = 3'd2;
    localparam logic [2:0] MODE_ATTR = 3'd3;
    localparam logic [2:0] MODE_URL  = 3'd4;

    // characters with an html entity, and the nul terminator
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef struct packed {
        logic [2:0]  mode;
        logic        ff_nl;
        logic [15:0] limit;
    } t_cfg;

    // expansion of one byte, index 0 goes out first
    typedef struct packed {
        logic [MAX_EXP-1:0][BYTE_W-1:0] chars;
        logic [SIZE_W-1:0]              size;
    } t_exp;

    // queue entry between front and back
    typedef struct packed {
        logic [MAX_EXP-1:0][BYTE_W-1:0] chars;
        logic [SIZE_W-1:0]              size;
        logic                           status;
        logic [LEN_W-1:0]               len;
    } t_job;

    function automatic logic [7:0] hex_digit(logic [3:0] v);
        logic [7:0] h;
        h = (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
        return h;
    endfunction

    function automatic logic is_alnum(logic [7:0] c);
        logic r;
        r = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
            (c >= 8'h61 && c <= 8'h7A);
        return r;
    endfunction

    function automatic t_exp expand(logic [7:0] c, logic [2:0] mode, logic ff_nl);
        t_exp       e;
        logic [7:0] hi;
        logic [7:0] lo;
        hi = hex_digit(c[7:4]);
        lo = hex_digit(c[3:0]);
        e.chars    = '0;
        e.chars[0] = c;
        e.size     = 3'd1;
        if (mode == MODE_HTML) begin
            unique case (c)
                CH_AMP: begin
                    e.chars = {8'h00, ";", "p", "m", "a", "&"};
                    e.size  = 3'd5;
                end
                CH_GT: begin
                    e.chars = {16'h0000, ";", "t", "g", "&"};
                    e.size  = 3'd4;
                end
                CH_LT: begin
                    e.chars = {16'h0000, ";", "t", "l", "&"};
                    e.size  = 3'd4;
                end
                CH_NL: begin
                    e.chars = ff_nl ? {";", "4", "2", "1", "#", "&"}
                                    : {";", "A", "0", "x", "#", "&"};
                    e.size  = 3'd6;
                end
                CH_SLASH: begin
                    e.chars = {";", "F", "2", "x", "#", "&"};
                    e.size  = 3'd6;
                end
                CH_DQUOT: begin
                    e.chars = {";", "t", "o", "u", "q", "&"};
                    e.size  = 3'd6;
                end
                CH_SQUOT: begin
                    e.chars = {8'h00, ";", "9", "3", "#", "&"};
                    e.size  = 3'd5;
                end
                default: begin
                end
            endcase
        end else if (!is_alnum(c)) begin
            unique case (mode)
                MODE_JS: begin
                    e.chars = {16'h0000, lo, hi, "x", "\\"};
                    e.size  = 3'd4;
                end
                MODE_CSS: begin
                    e.chars = {16'h0000, " ", lo, hi, "\\"};
                    e.size  = 3'd4;
                end
                MODE_ATTR: begin
                    e.chars = {";", lo, hi, "x", "#", "&"};
                    e.size  = 3'd6;
                end
                MODE_URL: begin
                    e.chars = {24'h000000, lo, hi, "%"};
                    e.size  = 3'd3;
                end
                default: begin
                end
            endcase
        end
        return e;
    endfunction

endpackage

// ===== rtl/mtee_stream_if.sv =====
// ----------------------------------------------------------------------------
// mtee_stream_if
// valid/ready channels for input bytes and escaped output bytes
// ----------------------------------------------------------------------------
interface mtee_in_if import mtee_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface mtee_out_if import mtee_pkg::*; ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_char;
    logic              run_last;
    logic              status;
    logic [LEN_W-1:0]  encoded_length;

    modport source (output valid, output out_char, output run_last, output status,
                    output encoded_length, input ready);
    modport sink (input valid, input out_char, input run_last, input status,
                  input encoded_length, output ready);
endinterface

// ===== rtl/mtee_fifo.sv =====
// ----------------------------------------------------------------------------
// mtee_fifo
// two-entry job queue between the classifying front and the emitting back
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtee_fifo import mtee_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_empty,
    output logic o_full
);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_head  = r_mem[r_rp];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // occupancy
    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    `ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, o_full, !i_push)
    `ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, o_empty, !i_pop)
    `ASSERT_NEXT(a_push_fills, i_clk, i_rst_n, i_push && !i_pop, r_cnt == $past(r_cnt) + 1'b1)

endmodule

// ===== rtl/mtee_front.sv =====
// ----------------------------------------------------------------------------
// mtee_front
// accepts input bytes, expands them, checks the limit and keeps the count
// ----------------------------------------------------------------------------
module mtee_front import mtee_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_cfg         i_cfg,
    mtee_in_if.sink      i_in,
    input  logic         i_full,
    output logic         o_push,
    output t_job         o_job
);

    localparam int CW = ((COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W) + 2;
    localparam int SW = COUNT_BITS + 1;

    logic [COUNT_BITS-1:0] r_wc;
    logic [COUNT_BITS-1:0] n_wc;
    logic                  r_ovf;
    logic                  n_ovf;
    logic                  accept;
    logic                  is_term;
    logic                  over;
    t_exp                  exp_c;
    logic [CW-1:0]         wc_ext;
    logic [CW-1:0]         need;
    logic [SW-1:0]         wsum;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign is_term    = (i_in.in_byte == CH_NUL);

    // expansion and limit check
    always_comb begin
        exp_c  = expand(i_in.in_byte, i_cfg.mode, i_cfg.ff_nl);
        wc_ext = CW'(r_wc);
        need   = wc_ext + CW'(exp_c.size) + CW'(1);
        over   = (i_cfg.limit != '0) && (need > CW'(i_cfg.limit));
        wsum   = {1'b0, r_wc} + SW'(exp_c.size);
    end

    // job to queue
    always_comb begin
        o_job        = '0;
        o_job.size   = SIZE_W'(1);
        o_push       = accept && !r_ovf;
        priority if (is_term) begin
            o_job.len = wc_ext[LEN_W-1:0];
        end else if (over) begin
            o_job.status = 1'b1;
            o_job.len    = wc_ext[LEN_W-1:0];
        end else begin
            o_job.chars = exp_c.chars;
            o_job.size  = exp_c.size;
        end
    end

    // count and overflow update
    always_comb begin
        n_wc  = r_wc;
        n_ovf = r_ovf;
        if (accept) begin
            priority if (r_ovf) begin
                if (is_term) begin
                    n_ovf = 1'b0;
                    n_wc  = '0;
                end
            end else if (is_term) begin
                n_wc = '0;
            end else if (over) begin
                n_ovf = 1'b1;
            end else begin
                n_wc = wsum[COUNT_BITS] ? '1 : wsum[COUNT_BITS-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wc  <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_wc  <= n_wc;
            r_ovf <= n_ovf;
        end
    end

endmodule

// ===== rtl/mtee_back.sv =====
// ----------------------------------------------------------------------------
// mtee_back
// walks the head job byte by byte into the output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mtee_back import mtee_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_job      i_head,
    input  logic      i_empty,
    output logic      o_pop,
    mtee_out_if.source o_out
);

    logic [SIZE_W-1:0] r_idx;
    logic              r_ov;
    logic [BYTE_W-1:0] r_char;
    logic              r_last;
    logic              r_status;
    logic [LEN_W-1:0]  r_len;
    logic              take;
    logic              fire;
    logic              is_last;

    assign take    = !r_ov || o_out.ready;
    assign fire    = take && !i_empty;
    assign is_last = (r_idx == i_head.size - 1'b1);
    assign o_pop   = fire && is_last;

    assign o_out.valid          = r_ov;
    assign o_out.out_char       = r_char;
    assign o_out.run_last       = r_last;
    assign o_out.status         = r_status;
    assign o_out.encoded_length = r_len;

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_char   <= i_head.chars[r_idx];
            r_last   <= is_last;
            r_status <= i_head.status;
            r_len    <= i_head.len;
        end
    end

    // byte index and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            r_ov  <= 1'b0;
        end else begin
            if (fire) begin
                r_ov  <= 1'b1;
                r_idx <= is_last ? '0 : r_idx + 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    `ASSERT_IMPL(a_idx_in_job, i_clk, i_rst_n, !i_empty, r_idx < i_head.size)
    `ASSERT_IMPL(a_err_is_term, i_clk, i_rst_n, r_ov && r_status,
        r_last && (r_char == CH_NUL))
    `ASSERT_IMPL(a_len_on_term, i_clk, i_rst_n, r_ov && (r_char != CH_NUL), r_len == '0)

endmodule

// ===== rtl/multi_mode_text_escape_encoder_top.sv =====
// ----------------------------------------------------------------------------
// multi_mode_text_escape_encoder_top
// html entity and hex escape encoder for zero-terminated byte strings
// ----------------------------------------------------------------------------
//   port     dir   kind           beat
//   i_in     in    valid/ready    in_byte
//   o_out    out   valid/ready    out_char, run_last, status, encoded_length
//   i_cfg_*  in    write strobe   register index and data
//
// a byte is classified and queued in the cycle it is accepted; the back end
// emits one output byte per cycle while o_out is ready, so plain bytes
// flow at one per cycle; an escaped byte holds the back end for all its bytes.
// the two-entry job queue sets how far input may run ahead of output.
// synchronous active-low reset clears count, overflow flag, queue and valid.
// ----------------------------------------------------------------------------
module multi_mode_text_escape_encoder_top import mtee_pkg::*; #(
    parameter int COUNT_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mtee_in_if.sink              i_in,
    mtee_out_if.source           o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [LEN_W-1:0]     i_cfg_data
);

    t_cfg r_cfg;
    logic push;
    logic pop;
    logic empty;
    logic full;
    t_job job;
    t_job head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:  r_cfg.mode  <= i_cfg_data[2:0];
                CFG_FF_NL: r_cfg.ff_nl <= i_cfg_data[0];
                CFG_LIMIT: r_cfg.limit <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    mtee_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job)
    );

    mtee_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_head  (head),
        .o_empty (empty),
        .o_full  (full)
    );

    mtee_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .i_empty (empty),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule
